// ===== rtl/core/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utt_pkg;

    localparam int QueueDepth = 2;

    localparam logic [15:0] SurrHighLo = 16'hD800;
    localparam logic [15:0] SurrHighHi = 16'hDBFF;
    localparam logic [15:0] SurrLowLo  = 16'hDC00;
    localparam logic [15:0] SurrLowHi  = 16'hDFFF;
    localparam logic [20:0] SuppBase   = 21'h10000;
    localparam logic [7:0]  LeadTwo    = 8'hC0;
    localparam logic [7:0]  LeadThree  = 8'hE0;
    localparam logic [7:0]  LeadFour   = 8'hF0;
    localparam logic [7:0]  ContMark   = 8'h80;
    localparam logic [7:0]  ContMask   = 8'h3F;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_END_SURR    = 2'd1,
        ST_HIGH_NO_LOW = 2'd2,
        ST_LONE_LOW    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       start_of_text;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       text_done;
        t_status    status;
    } t_out_item;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            eot;
        t_status         status;
    } t_job;

endpackage

// ===== rtl/core/utt_front.sv =====
// ----------------------------------------------------------------------------
// utt_front
// Accepts code units, tracks surrogates and faults, and builds byte jobs.
// ----------------------------------------------------------------------------
module utt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_in_valid,
    input  utt_pkg::t_in_item i_in_data,
    output logic            o_in_stall,
    input  logic            i_q_full,
    output logic            o_push,
    output utt_pkg::t_job   o_push_job
);

    logic       r_msb_first;
    logic       r_high_pending;
    logic [9:0] r_held_high_bits;
    logic       r_fault_seen;

    logic       n_high_pending;
    logic [9:0] n_held_high_bits;
    logic       n_fault_seen;

    logic        accept;
    logic [15:0] unit;
    logic        is_high;
    logic        is_low;
    logic        eff_pend;
    logic        eff_fault;
    logic [20:0] cp;
    logic        use_cp;
    logic        use_err;
    utt_pkg::t_status err_code;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        unit = r_msb_first ? {i_in_data.first_byte, i_in_data.second_byte}
                           : {i_in_data.second_byte, i_in_data.first_byte};
        is_high   = unit inside {[utt_pkg::SurrHighLo:utt_pkg::SurrHighHi]};
        is_low    = unit inside {[utt_pkg::SurrLowLo:utt_pkg::SurrLowHi]};
        eff_pend  = r_high_pending && !i_in_data.start_of_text;
        eff_fault = r_fault_seen && !i_in_data.start_of_text;

        n_high_pending   = eff_pend;
        n_held_high_bits = i_in_data.start_of_text ? 10'd0 : r_held_high_bits;
        n_fault_seen     = eff_fault;
        use_cp   = 1'b0;
        use_err  = 1'b0;
        err_code = utt_pkg::ST_OK;
        cp       = {5'd0, unit};

        if (eff_fault) begin
            use_cp = 1'b0;
        end else if (eff_pend) begin
            n_high_pending   = 1'b0;
            n_held_high_bits = 10'd0;
            if (!is_low) begin
                use_err      = 1'b1;
                err_code     = utt_pkg::ST_HIGH_NO_LOW;
                n_fault_seen = 1'b1;
            end else begin
                use_cp = 1'b1;
                cp     = utt_pkg::SuppBase + {1'b0, r_held_high_bits, unit[9:0]};
            end
        end else if (is_high) begin
            if (i_in_data.end_of_text) begin
                use_err      = 1'b1;
                err_code     = utt_pkg::ST_END_SURR;
                n_fault_seen = 1'b1;
            end else begin
                n_high_pending   = 1'b1;
                n_held_high_bits = unit[9:0];
            end
        end else if (is_low) begin
            use_err      = 1'b1;
            err_code     = utt_pkg::ST_LONE_LOW;
            n_fault_seen = 1'b1;
        end else begin
            use_cp = 1'b1;
        end
    end

    always_comb begin
        o_push_job.bytes    = '0;
        o_push_job.last_idx = 2'd0;
        o_push_job.eot      = i_in_data.end_of_text;
        o_push_job.status   = utt_pkg::ST_OK;
        if (use_err) begin
            o_push_job.eot    = 1'b1;
            o_push_job.status = err_code;
        end else if (cp < 21'h80) begin
            o_push_job.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            o_push_job.bytes[0] = utt_pkg::LeadTwo | {3'd0, cp[10:6]};
            o_push_job.bytes[1] = utt_pkg::ContMark | (cp[7:0] & utt_pkg::ContMask);
            o_push_job.last_idx = 2'd1;
        end else if (cp < utt_pkg::SuppBase) begin
            o_push_job.bytes[0] = utt_pkg::LeadThree | {4'd0, cp[15:12]};
            o_push_job.bytes[1] = utt_pkg::ContMark | {2'd0, cp[11:6]};
            o_push_job.bytes[2] = utt_pkg::ContMark | (cp[7:0] & utt_pkg::ContMask);
            o_push_job.last_idx = 2'd2;
        end else begin
            o_push_job.bytes[0] = utt_pkg::LeadFour | {5'd0, cp[20:18]};
            o_push_job.bytes[1] = utt_pkg::ContMark | {2'd0, cp[17:12]};
            o_push_job.bytes[2] = utt_pkg::ContMark | {2'd0, cp[11:6]};
            o_push_job.bytes[3] = utt_pkg::ContMark | (cp[7:0] & utt_pkg::ContMask);
            o_push_job.last_idx = 2'd3;
        end
    end

    assign o_push = accept && (use_cp || use_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msb_first      <= 1'b0;
            r_high_pending   <= 1'b0;
            r_held_high_bits <= 10'd0;
            r_fault_seen     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_msb_first <= i_cfg_wdata;
            end
            if (accept) begin
                r_high_pending   <= n_high_pending;
                r_held_high_bits <= n_held_high_bits;
                r_fault_seen     <= n_fault_seen;
            end
        end
    end

endmodule

// ===== rtl/core/utt_queue.sv =====
// ----------------------------------------------------------------------------
// utt_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module utt_queue #(
    parameter int Depth = utt_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utt_pkg::t_job i_push_job,
    output logic          o_full,
    output logic          o_valid,
    output utt_pkg::t_job o_job,
    input  logic          i_pop
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    utt_pkg::t_job   r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_push_job;
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("Queue count exceeds its depth.");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("Queue popped while empty.");
`endif

endmodule

// ===== rtl/core/utt_back.sv =====
// ----------------------------------------------------------------------------
// utt_back
// Plays out each job as one output word per cycle through an output register, unless the receiver stalls.
// ----------------------------------------------------------------------------
module utt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  utt_pkg::t_job      i_q_job,
    output logic               o_pop,
    output logic               o_out_valid,
    output utt_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    utt_pkg::t_job      r_job;
    logic               r_busy;
    logic [1:0]         r_idx;
    logic               r_out_valid;
    utt_pkg::t_out_item r_out;

    logic can_load;
    logic is_last;
    logic finish;

    assign can_load = !r_out_valid || !i_out_stall;
    assign is_last  = (r_idx == r_job.last_idx);
    assign finish   = r_busy && can_load && is_last;
    assign o_pop    = i_q_valid && (!r_busy || finish);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_job  <= i_q_job;
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (finish) begin
                r_busy <= 1'b0;
            end else if (r_busy && can_load) begin
                r_idx <= r_idx + 2'd1;
            end
            if (r_busy && can_load) begin
                r_out_valid       <= 1'b1;
                r_out.out_byte    <= r_job.bytes[r_idx];
                r_out.last_of_run <= is_last;
                r_out.text_done   <= is_last && r_job.eot;
                r_out.status      <= r_job.status;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.text_done |-> r_out.last_of_run)
        else $error("Text end flagged on a word that does not end its run.");
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status != utt_pkg::ST_OK)
        |-> r_out.last_of_run && r_out.text_done && (r_out.out_byte == 8'd0))
        else $error("Error word is not a single closing zero word.");
`endif

endmodule

// ===== rtl/core/utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a stream of UTF-16 code units into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Each input word carries one code unit as two bytes in stream order, with
// start and end of text marks. The byte order follows the big endian
// configuration bit, written through i_cfg_we and i_cfg_wdata; the user
// must write it only while idle, as the block does not enforce this. Each
// output word carries one UTF-8 byte with a last-of-run mark, a text done
// mark and a status code; a fault gives a single zero word with a nonzero
// status, and the rest of that text is dropped. The front part decodes one
// unit per cycle unless the queue is full and pushes a job into a short
// queue; the back part sends one byte per cycle from an output register
// unless the receiver stalls. A code point gives one to four bytes, and the
// next job loads as the last byte of the one before goes. A held high
// surrogate produces no word until its partner arrives. When the receiver
// stalls, the output word holds, the queue fills and the input stall rises.
// Reset clears the queue, the surrogate and fault state, and sets the byte
// order to little endian.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = utt_pkg::QueueDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    input  utt_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output utt_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    logic          push;
    utt_pkg::t_job push_job;
    logic          q_full;
    logic          q_valid;
    utt_pkg::t_job q_job;
    logic          pop;

    utt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_job  (push_job)
    );

    utt_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_job      (q_job),
        .i_pop      (pop)
    );

    utt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
